@@ sv/arm_fire_controller_core_defines.svh @@
// ----------------------------------------------------------------------------
// arm fire controller assertion macros
// shared concurrent assertion forms for the controller rtl
// ----------------------------------------------------------------------------
`ifndef ARM_FIRE_CONTROLLER_CORE_DEFINES_SVH
`define ARM_FIRE_CONTROLLER_CORE_DEFINES_SVH

// checked only while out of reset
`define AFC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AFC_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// arm fire controller package
// shared types, codes, reset values and the quarter sine table
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int LEVEL_BITS_DEF = 8;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LED_W      = 8;

    typedef enum logic [1:0] {
        MODE_STARTUP = 2'd0,
        MODE_READY   = 2'd1,
        MODE_ARMED   = 2'd2,
        MODE_FIRING  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        MSG_NONE     = 3'd0,
        MSG_READY    = 3'd1,
        MSG_ARMED    = 3'd2,
        MSG_DISARMED = 3'd3,
        MSG_FIRING   = 3'd4,
        MSG_FIRED    = 3'd5
    } t_msg;

    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_MS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRING_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd4;

    localparam logic [15:0] STARTUP_MS_RST  = 16'd1000;
    localparam logic [15:0] FIRING_MS_RST   = 16'd5000;
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd1000;
    localparam logic [9:0]  BLINK_MS_RST    = 10'd100;
    localparam logic [12:0] PHASE_STEP_RST  = 13'd5;

    // quarter sine in q15, 17 points over a quarter cycle
    function automatic logic [15:0] sine_tab(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/arm_fire_controller_core.sv @@
// ----------------------------------------------------------------------------
// arm fire controller core
// One input word per millisecond tick. An accepted tick is registered in
// the stage register, then in the output register, which its words leave.
// A two-message tick holds the single output register for both words, so
// the input stalls behind it; every other tick flows at one per cycle
// while the result side takes every word. The sequencer and timers update
// in the accepting cycle, the LED level is worked out from the stage register
// (sine table, one interpolation multiply) on its way into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_fire_controller_core #(
    parameter int PHASE_BITS = afc_pkg::PHASE_BITS_DEF,
    parameter int LEVEL_BITS = afc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // tick input
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // arm_switch_level, trigger_press, zero pad
    input  wire logic [afc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // result output
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // mode_state, power_led, fire_led_level, message, zero pad
    output logic [afc_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast
);
    import afc_pkg::*;

    `include "arm_fire_controller_core_defines.svh"

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    // configuration
    logic [15:0]           r_startup_ms;
    logic [15:0]           r_firing_ms;
    logic [15:0]           r_debounce_ms;
    logic [9:0]            r_blink_ms;
    logic [12:0]           r_phase_step;

    // sequencer state
    t_mode                 r_mode, n_mode;
    logic [15:0]           r_phase_timer, n_phase_timer;
    logic [9:0]            r_blink_timer, n_blink_timer;
    logic [15:0]           r_since, n_since;
    logic [PHASE_BITS-1:0] r_pulse_phase, n_pulse_phase;
    logic                  r_blink_on, n_blink_on;

    // stage register
    logic                  r_s1_valid;
    t_mode                 r_s1_mode;
    logic                  r_s1_blink;
    logic [PHASE_BITS-1:0] r_s1_phase;
    t_msg                  r_s1_msg0, r_s1_msg1;
    logic                  r_s1_two;
    t_msg                  n_msg0, n_msg1;
    logic                  n_two;

    // output register
    logic                  r_o_valid;
    t_mode                 r_o_mode;
    logic [LED_W-1:0]      r_o_level;
    t_msg                  r_o_msg, r_o_msg2;
    logic                  r_o_last;

    logic in_acc, out_take, out_free, s1_move;
    logic sw, press;

    assign sw    = i_s_tdata[0];
    assign press = i_s_tdata[1];

    assign out_take   = r_o_valid && i_m_tready;
    assign out_free   = !r_o_valid || (out_take && r_o_last);
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || s1_move;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_ms  <= STARTUP_MS_RST;
            r_firing_ms   <= FIRING_MS_RST;
            r_debounce_ms <= DEBOUNCE_MS_RST;
            r_blink_ms    <= BLINK_MS_RST;
            r_phase_step  <= PHASE_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STARTUP_MS:  r_startup_ms  <= i_cfg_data;
                CFG_FIRING_MS:   r_firing_ms   <= i_cfg_data;
                CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data;
                CFG_BLINK_MS:    r_blink_ms    <= i_cfg_data[9:0];
                CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // tick conditions
    logic [15:0]              since_inc, pt_inc;
    logic [9:0]               bt_inc;
    logic                     trig_ok, fire_go, startup_done, firing_done, blink_done;
    logic [PHASE_BITS+12:0]   phase_sum;

    assign since_inc    = (r_since == 16'hFFFF) ? r_since : r_since + 16'd1;
    assign pt_inc       = (r_phase_timer == 16'hFFFF) ? r_phase_timer : r_phase_timer + 16'd1;
    assign bt_inc       = (r_blink_timer == 10'h3FF) ? r_blink_timer : r_blink_timer + 10'd1;
    assign trig_ok      = press && (since_inc > r_debounce_ms);
    assign fire_go      = trig_ok && (r_mode == MODE_ARMED);
    assign startup_done = pt_inc >= r_startup_ms;
    assign firing_done  = pt_inc >= r_firing_ms;
    assign blink_done   = bt_inc >= r_blink_ms;
    assign phase_sum    = {13'd0, r_pulse_phase} + {{PHASE_BITS{1'b0}}, r_phase_step};
    assign n_since      = trig_ok ? 16'd0 : since_inc;

    // next state
    always_comb begin
        n_mode = r_mode;
        if (fire_go) begin
            n_mode = MODE_FIRING;
        end else begin
            unique case (r_mode)
                MODE_STARTUP: if (startup_done) n_mode = MODE_READY;
                MODE_READY:   if (!sw) n_mode = MODE_ARMED;
                MODE_ARMED:   if (sw) n_mode = MODE_READY;
                MODE_FIRING:  if (firing_done) n_mode = MODE_ARMED;
            endcase
        end
    end

    // timers, pulse phase and messages
    always_comb begin
        n_phase_timer = r_phase_timer;
        n_blink_timer = r_blink_timer;
        n_blink_on    = r_blink_on;
        n_pulse_phase = r_pulse_phase;
        n_msg0        = MSG_NONE;
        n_msg1        = MSG_NONE;
        n_two         = 1'b0;
        if (fire_go) begin
            n_phase_timer = 16'd0;
            n_blink_timer = 10'd0;
            n_blink_on    = 1'b1;
            n_msg0        = MSG_FIRING;
        end else begin
            unique case (r_mode)
                MODE_STARTUP: begin
                    n_phase_timer = startup_done ? 16'd0 : pt_inc;
                    if (startup_done) n_msg0 = MSG_READY;
                end
                MODE_READY: begin
                    if (!sw) begin
                        n_pulse_phase = '0;
                        n_msg0        = MSG_ARMED;
                    end
                end
                MODE_ARMED: begin
                    if (!sw) begin
                        n_pulse_phase = phase_sum[PHASE_BITS-1:0];
                    end else begin
                        n_msg0 = MSG_DISARMED;
                        n_msg1 = MSG_READY;
                        n_two  = 1'b1;
                    end
                end
                MODE_FIRING: begin
                    n_blink_timer = blink_done ? 10'd0 : bt_inc;
                    n_blink_on    = blink_done ? !r_blink_on : r_blink_on;
                    n_phase_timer = pt_inc;
                    if (firing_done) begin
                        n_phase_timer = 16'd0;
                        n_blink_timer = 10'd0;
                        n_blink_on    = 1'b0;
                        n_pulse_phase = '0;
                        n_msg0        = MSG_FIRED;
                        if (!sw) begin
                            n_msg1 = MSG_ARMED;
                            n_two  = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STARTUP;
            r_phase_timer <= 16'd0;
            r_blink_timer <= 10'd0;
            r_since       <= 16'd0;
            r_pulse_phase <= '0;
            r_blink_on    <= 1'b0;
        end else if (in_acc) begin
            r_mode        <= n_mode;
            r_phase_timer <= n_phase_timer;
            r_blink_timer <= n_blink_timer;
            r_since       <= n_since;
            r_pulse_phase <= n_pulse_phase;
            r_blink_on    <= n_blink_on;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode  <= n_mode;
            r_s1_blink <= n_blink_on;
            r_s1_phase <= n_pulse_phase;
            r_s1_msg0  <= n_msg0;
            r_s1_msg1  <= n_msg1;
            r_s1_two   <= n_two;
        end
    end

    // raised cosine level
    logic [PHASE_BITS+15:0]   phase_ext;
    logic [15:0]              p16, p;
    logic [1:0]               q;
    logic [14:0]              x;
    logic [4:0]               idx;
    logic [9:0]               frac;
    logic [15:0]              tab_lo, tab_hi, diff, sine;
    logic [25:0]              interp;
    logic [16:0]              num;
    logic [LEVEL_BITS+17:0]   scaled;
    logic [LEVEL_BITS-1:0]    pulse_lvl, lvl;
    logic [LEVEL_BITS+7:0]    lvl_ext;

    assign phase_ext = {r_s1_phase, 16'd0};
    assign p16       = phase_ext[PHASE_BITS+15 -: 16];
    assign p         = p16 + 16'd16384;
    assign q         = p[15:14];
    assign x         = q[0] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    assign idx       = x[14:10];
    assign frac      = x[9:0];
    assign tab_lo    = sine_tab(idx);
    assign tab_hi    = sine_tab(idx + 5'd1);
    assign diff      = tab_hi - tab_lo;
    assign interp    = {10'd0, diff} * {16'd0, frac};
    assign sine      = idx[4] ? 16'd32768 : tab_lo + interp[25:10];
    assign num       = q[1] ? (17'd32768 + {1'b0, sine}) : (17'd32768 - {1'b0, sine});
    assign scaled    = {1'b0, num, {LEVEL_BITS{1'b0}}} - {{(LEVEL_BITS+1){1'b0}}, num}
                       + {{(LEVEL_BITS+2){1'b0}}, 16'd32768};
    assign pulse_lvl = scaled[16 +: LEVEL_BITS];

    always_comb begin
        case (r_s1_mode)
            MODE_FIRING: lvl = r_s1_blink ? LEVEL_MAX : '0;
            MODE_ARMED:  lvl = pulse_lvl;
            default:     lvl = '0;
        endcase
    end

    assign lvl_ext = {8'd0, lvl};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (out_take && r_o_last) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_mode  <= r_s1_mode;
            r_o_level <= lvl_ext[LED_W-1:0];
            r_o_msg   <= r_s1_msg0;
            r_o_msg2  <= r_s1_msg1;
            r_o_last  <= !r_s1_two;
        end else if (out_take && !r_o_last) begin
            r_o_msg  <= r_o_msg2;
            r_o_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {2'b00, r_o_msg, r_o_level, 1'b1, r_o_mode};

    `AFC_ASSERT_ANY(a_out_idle_after_rst, !i_rst_n |=> !r_o_valid, "valid after reset")
    `AFC_ASSERT_RUN(a_pend_msg, r_o_valid && !r_o_last |-> r_o_msg2 != MSG_NONE, "no second msg")
    `AFC_ASSERT_RUN(a_quiet, r_o_valid && r_o_msg == MSG_NONE |-> r_o_last, "quiet not last")
    `AFC_ASSERT_RUN(a_start_phase, r_mode == MODE_STARTUP |-> r_pulse_phase == '0, "phase moved")
    `AFC_ASSERT_RUN(a_fire, in_acc && fire_go |=> r_mode == MODE_FIRING && r_blink_on, "no firing")

endmodule

`default_nettype wire

@@ verif/afc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm fire controller checker
// Watches the configuration, tick and result channels of the controller.
// Every accepted tick runs through a cycle-free model of the sequencer, the
// debounce and blink timers and the raised-cosine pulse, and the words it
// should cause are queued. Every accepted result word is compared field by
// field with the oldest queued word.
// ----------------------------------------------------------------------------

module afc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [afc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [afc_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  wire logic                            i_m_tlast,
    output int                                   o_errors,
    output logic                                 o_busy
);
    import afc_pkg::*;

    typedef struct {
        t_mode       mode;
        logic        powered;
        logic [7:0]  level;
        t_msg        msg;
        logic        last;
    } t_word;

    localparam int unsigned SINE_Q15 [17] = '{
        0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
        25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768
    };

    logic [15:0] cfg_startup, cfg_firing, cfg_debounce;
    logic [9:0]  cfg_blink;
    logic [12:0] cfg_step;

    t_mode       mode;
    logic [15:0] stage_timer;
    logic [9:0]  blink_timer;
    logic [15:0] since_press;
    logic [15:0] pulse_phase;
    logic        blink_on;

    t_msg        tick_msgs [2];
    int          tick_msg_cnt;
    t_word       due_words [$];
    int          errors = 0;

    function automatic int unsigned quarter_sine(input int unsigned x);
        int unsigned idx, frac;
        idx  = x >> 10;
        frac = x & 1023;
        if (idx >= 16) begin
            return 32768;
        end
        return SINE_Q15[idx] + (((SINE_Q15[idx+1] - SINE_Q15[idx]) * frac) >> 10);
    endfunction

    // phase 0 is dark, half a cycle is full brightness
    function automatic logic [7:0] pulse_brightness(input logic [15:0] ph);
        int unsigned p, quad, rem, s, num;
        p    = (ph + 16384) & 16'hFFFF;
        quad = p >> 14;
        rem  = p & 16'h3FFF;
        s    = ((quad & 1) != 0) ? quarter_sine(16384 - rem) : quarter_sine(rem);
        num  = (quad < 2) ? (32768 - s) : (32768 + s);
        return 8'(((num * 255) + 32768) >> 16);
    endfunction

    task automatic post_msg(input t_msg m);
        tick_msgs[tick_msg_cnt] = m;
        tick_msg_cnt++;
    endtask

    task automatic enter_armed(input logic sw);
        mode        = MODE_ARMED;
        pulse_phase = '0;
        if (!sw) begin
            post_msg(MSG_ARMED);
        end
    endtask

    task automatic advance_tick(input logic sw, input logic press);
        logic       fired_now;
        logic [7:0] lvl;
        t_word      w;
        int         count;
        fired_now    = 1'b0;
        tick_msg_cnt = 0;
        if (since_press != 16'hFFFF) begin
            since_press++;
        end
        if (press && since_press > cfg_debounce) begin
            since_press = '0;
            if (mode == MODE_ARMED) begin
                mode        = MODE_FIRING;
                post_msg(MSG_FIRING);
                stage_timer = '0;
                blink_timer = '0;
                blink_on    = 1'b1;
                fired_now   = 1'b1;
            end
        end
        if (!fired_now) begin
            case (mode)
                MODE_STARTUP: begin
                    if (stage_timer != 16'hFFFF) begin
                        stage_timer++;
                    end
                    if (stage_timer >= cfg_startup) begin
                        stage_timer = '0;
                        mode        = MODE_READY;
                        post_msg(MSG_READY);
                    end
                end
                MODE_READY: begin
                    if (!sw) begin
                        enter_armed(sw);
                    end
                end
                MODE_ARMED: begin
                    if (!sw) begin
                        pulse_phase = pulse_phase + {3'b0, cfg_step};
                    end else begin
                        post_msg(MSG_DISARMED);
                        mode = MODE_READY;
                        post_msg(MSG_READY);
                    end
                end
                default: begin
                    if (blink_timer != 10'h3FF) begin
                        blink_timer++;
                    end
                    if (blink_timer >= cfg_blink) begin
                        blink_timer = '0;
                        blink_on    = ~blink_on;
                    end
                    if (stage_timer != 16'hFFFF) begin
                        stage_timer++;
                    end
                    if (stage_timer >= cfg_firing) begin
                        stage_timer = '0;
                        blink_timer = '0;
                        blink_on    = 1'b0;
                        post_msg(MSG_FIRED);
                        enter_armed(sw);
                    end
                end
            endcase
        end
        if (mode == MODE_FIRING) begin
            lvl = blink_on ? 8'hFF : 8'h00;
        end else if (mode == MODE_ARMED) begin
            lvl = pulse_brightness(pulse_phase);
        end else begin
            lvl = 8'h00;
        end
        count = (tick_msg_cnt == 0) ? 1 : tick_msg_cnt;
        for (int k = 0; k < count; k++) begin
            w.mode    = mode;
            w.powered = 1'b1;
            w.level   = lvl;
            w.msg     = (tick_msg_cnt == 0) ? MSG_NONE : tick_msgs[k];
            w.last    = (k == count - 1);
            due_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_word exp_w;
        if (!i_rst_n) begin
            cfg_startup  = STARTUP_MS_RST;
            cfg_firing   = FIRING_MS_RST;
            cfg_debounce = DEBOUNCE_MS_RST;
            cfg_blink    = BLINK_MS_RST;
            cfg_step     = PHASE_STEP_RST;
            mode         = MODE_STARTUP;
            stage_timer  = '0;
            blink_timer  = '0;
            since_press  = '0;
            pulse_phase  = '0;
            blink_on     = 1'b0;
            due_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_words.size() == 0) begin
                    $error("result word 0x%h with no tick pending", i_m_tdata);
                    errors++;
                end else begin
                    exp_w = due_words.pop_front();
                    if (i_m_tdata[1:0] !== exp_w.mode) begin
                        $error("mode_state expected %0d got %0d", exp_w.mode, i_m_tdata[1:0]);
                        errors++;
                    end
                    if (i_m_tdata[2] !== exp_w.powered) begin
                        $error("power_led expected %0d got %0d", exp_w.powered, i_m_tdata[2]);
                        errors++;
                    end
                    if (i_m_tdata[10:3] !== exp_w.level) begin
                        $error("fire_led_level expected %0d got %0d",
                               exp_w.level, i_m_tdata[10:3]);
                        errors++;
                    end
                    if (i_m_tdata[13:11] !== exp_w.msg) begin
                        $error("message expected %0d got %0d", exp_w.msg, i_m_tdata[13:11]);
                        errors++;
                    end
                    if (i_m_tlast !== exp_w.last) begin
                        $error("last_of_tick expected %0d got %0d", exp_w.last, i_m_tlast);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STARTUP_MS:  cfg_startup  = i_cfg_data;
                    CFG_FIRING_MS:   cfg_firing   = i_cfg_data;
                    CFG_DEBOUNCE_MS: cfg_debounce = i_cfg_data;
                    CFG_BLINK_MS:    cfg_blink    = i_cfg_data[9:0];
                    CFG_PHASE_STEP:  cfg_step     = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_tick(i_s_tdata[0], i_s_tdata[1]);
            end
        end
        o_errors <= errors;
        o_busy   <= (due_words.size() != 0);
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm fire controller testbench
// Drives millisecond ticks into the controller in random bursts while the
// result side stalls on changing patterns. A short hand-built tick sequence
// walks through startup, arming, firing with the switch closed and open,
// and disarming; then several register settings, the extremes among them,
// each get a few hundred ticks of mostly steady switch levels with sparse
// trigger presses and some noise. The checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------

module tb;
    import afc_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASES       = 6;
    localparam int PHASE_TICKS  = 222;

    typedef enum logic [2:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_COMB,
        SINK_CHOKED
    } t_sink;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tlast;

    int    errors;
    logic  busy;
    int    cycle_count = 0;
    int    burst_left  = 0;
    t_sink sink_mode   = SINK_OPEN;
    int    sink_left   = 0;

    // press, switch level for each opening tick
    logic [1:0] opening [22] = '{
        2'b11, 2'b00, 2'b01, 2'b11, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00,
        2'b10, 2'b10, 2'b01, 2'b11, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b10
    };

    always #5 i_clk = ~i_clk;

    arm_fire_controller_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    afc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .o_errors    (errors),
        .o_busy      (busy)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure, switching pattern every so often
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink'($urandom_range(0, 4));
            sink_left = $urandom_range(20, 200);
        end else begin
            sink_left = sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   i_m_tready <= 1'b1;
            SINK_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            SINK_MOSTLY: i_m_tready <= ($urandom_range(0, 3) != 0);
            SINK_COMB:   i_m_tready <= ((cycle_count % 5) != 0);
            default:     i_m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] startup, input logic [15:0] firing,
                                 input logic [15:0] debounce, input logic [15:0] blink,
                                 input logic [15:0] step);
        write_reg(CFG_STARTUP_MS, startup);
        write_reg(CFG_FIRING_MS, firing);
        write_reg(CFG_DEBOUNCE_MS, debounce);
        write_reg(CFG_BLINK_MS, blink);
        write_reg(CFG_PHASE_STEP, step);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic sw, input logic press);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(30, 80);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_DATA_W-2){1'b0}}, press, sw};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] startup, firing, debounce, blink, step;
        logic        sw_level;
        logic        sw, press;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(16'd3, 16'd3, 16'd1, 16'd1, 16'd4096);
        foreach (opening[i]) begin
            send_tick(opening[i][0], opening[i][1]);
        end
        wait_quiet();

        sw_level = 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            startup  = 16'($urandom_range(1, 65535));
            firing   = 16'($urandom_range(1, 40));
            debounce = 16'($urandom_range(0, 20));
            blink    = 16'($urandom_range(1, 8));
            step     = 16'($urandom_range(1, 4096));
            case (p)
                0: begin
                    startup  = 16'd1;
                    firing   = 16'd1;
                    debounce = 16'd0;
                    blink    = 16'd1;
                    step     = 16'd1;
                end
                1: begin
                    startup  = 16'd65535;
                    firing   = 16'd65535;
                    blink    = 16'd1023;
                    step     = 16'd4096;
                end
                2: debounce = 16'd65535;
                3: begin
                    firing = 16'($urandom_range(1, 65535));
                    blink  = 16'($urandom_range(1, 1023));
                end
                default: ;
            endcase
            load_settings(startup, firing, debounce, blink, step);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(0, 24) == 0) begin
                    sw_level = ~sw_level;
                end
                sw    = sw_level;
                press = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    sw    = 1'($urandom_range(0, 1));
                    press = 1'($urandom_range(0, 1));
                end
                send_tick(sw, press);
            end
            wait_quiet();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
